// File: rtl/core/wsg_pkg.sv
// Shared types and constants of the whitespace row-gap segmenter.
// Depends on nothing; every other file of the block imports it.
package wsg_pkg;

    // pixel channel and energy widths
    localparam int CHAN_W   = 8;
    localparam int ENERGY_W = 18;

    // configuration register widths and reset values
    localparam int THRESH_W   = 18;
    localparam int GAP_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 18'd62500;
    localparam logic [GAP_W-1:0]    GAP_RESET    = 12'd50;

    // result row fields are fixed at 12 bits
    localparam int SEG_W = 12;

    // classification queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHITE_THRESHOLD = 1'b0,
        CFG_MIN_GAP         = 1'b1
    } cfg_idx_t;

    // classified pixel as stored in the queue
    typedef struct packed {
        logic ink;
        logic row_end;
        logic image_end;
    } pix_class_t;

    // one segment result
    typedef struct packed {
        logic [SEG_W-1:0] seg_top;
        logic [SEG_W-1:0] seg_end;
        logic             closing;
        logic             last;
    } seg_res_t;

endpackage

// File: rtl/core/wsg_if.sv
// Stream interfaces of the segmenter: pixel input and segment output.
// Depends on wsg_pkg for field widths.
interface wsg_pix_if;
    import wsg_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              row_end;
    logic              image_end;

    modport source (output valid, red, green, blue, row_end, image_end, input ready);
    modport sink   (input valid, red, green, blue, row_end, image_end, output ready);
endinterface

interface wsg_seg_if;
    import wsg_pkg::*;
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] seg_top;
    logic [SEG_W-1:0] seg_end;
    logic             closing;
    logic             last;

    modport source (output valid, seg_top, seg_end, closing, last, input ready);
    modport sink   (input valid, seg_top, seg_end, closing, last, output ready);
endinterface

// File: rtl/core/wsg_front.sv
// Front end: accepts pixels and classifies each as ink or white.
// Depends on wsg_pkg and wsg_pix_if; feeds wsg_queue.
module wsg_front (
    wsg_pix_if.sink                          pix,
    input  logic [wsg_pkg::THRESH_W-1:0]     white_threshold,
    input  logic                             queue_full,
    output logic                             push,
    output wsg_pkg::pix_class_t              push_data
);
    import wsg_pkg::*;

    logic [2*CHAN_W-1:0] red_sq;
    logic [2*CHAN_W-1:0] green_sq;
    logic [2*CHAN_W-1:0] blue_sq;
    logic [ENERGY_W-1:0] energy;

    // square and sum the channels
    always_comb
    begin
        red_sq   = pix.red * pix.red;
        green_sq = pix.green * pix.green;
        blue_sq  = pix.blue * pix.blue;
        energy   = ENERGY_W'(red_sq) + ENERGY_W'(green_sq) + ENERGY_W'(blue_sq);
    end

    // take an item whenever the queue has room
    assign pix.ready = !queue_full;
    assign push      = pix.valid && !queue_full;

    always_comb
    begin
        push_data.ink       = (energy <= ENERGY_W'(white_threshold));
        push_data.row_end   = pix.row_end;
        push_data.image_end = pix.image_end;
    end

endmodule

// File: rtl/core/wsg_queue.sv
// Short queue of classified pixels between front and back end.
// Depends on wsg_pkg for the entry type and depth.
module wsg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wsg_pkg::pix_class_t push_data,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output wsg_pkg::pix_class_t head_data
);
    import wsg_pkg::*;

    pix_class_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// File: rtl/core/wsg_back.sv
// Back end: walks classified pixels through the row and segment tracking
// and drives the segment output. Depends on wsg_pkg and wsg_seg_if.
module wsg_back #(
    parameter int ROW_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [wsg_pkg::GAP_W-1:0]     min_gap,
    input  logic                          head_valid,
    input  wsg_pkg::pix_class_t           head_data,
    output logic                          pop,
    wsg_seg_if.source                     seg
);
    import wsg_pkg::*;

    localparam int CMP_W = (ROW_BITS > GAP_W) ? ROW_BITS : GAP_W;

    // tracking state
    logic [ROW_BITS-1:0] row_index_reg;
    logic [ROW_BITS-1:0] row_index_next;
    logic [ROW_BITS-1:0] segment_top_reg;
    logic [ROW_BITS-1:0] segment_top_next;
    logic [ROW_BITS-1:0] white_run_start_reg;
    logic [ROW_BITS-1:0] white_run_start_next;
    logic                in_white_reg;
    logic                in_white_next;
    logic                row_has_ink_reg;
    logic                row_has_ink_next;

    // output register and second-result hold
    logic     out_valid_reg;
    seg_res_t out_res_reg;
    logic     pend_valid_reg;
    seg_res_t pend_res_reg;

    logic                out_free;
    logic                ink_first;
    logic                split;
    logic [ROW_BITS-1:0] gap;
    logic [ROW_BITS-1:0] seg_top_mid;
    logic                in_white_mid;
    logic                row_has_ink_mid;
    logic                in_white_end;
    logic [ROW_BITS-1:0] white_start_end;
    seg_res_t            split_res;
    seg_res_t            close_res;

    assign out_free = !out_valid_reg || seg.ready;
    assign pop      = head_valid && !pend_valid_reg && out_free;

    // step the tracking state for the head item
    always_comb
    begin
        gap       = row_index_reg - white_run_start_reg;
        ink_first = head_data.ink && !row_has_ink_reg;
        split     = ink_first && in_white_reg && (CMP_W'(gap) >= CMP_W'(min_gap));

        row_has_ink_mid = row_has_ink_reg || head_data.ink;
        in_white_mid    = in_white_reg && !ink_first;
        seg_top_mid     = split ? row_index_reg : segment_top_reg;

        in_white_end    = in_white_mid;
        white_start_end = white_run_start_reg;
        if ((head_data.row_end || head_data.image_end) && !row_has_ink_mid && !in_white_mid)
        begin
            in_white_end    = 1'b1;
            white_start_end = row_index_reg;
        end

        split_res.seg_top = SEG_W'(segment_top_reg);
        split_res.seg_end = SEG_W'(white_run_start_reg);
        split_res.closing = 1'b0;
        split_res.last    = !head_data.image_end;

        close_res.seg_top = SEG_W'(seg_top_mid);
        close_res.seg_end = in_white_end ? SEG_W'(white_start_end) : SEG_W'(row_index_reg);
        close_res.closing = 1'b1;
        close_res.last    = 1'b1;

        row_index_next       = row_index_reg;
        segment_top_next     = seg_top_mid;
        white_run_start_next = white_start_end;
        in_white_next        = in_white_end;
        row_has_ink_next     = row_has_ink_mid;
        if (head_data.image_end)
        begin
            row_index_next       = '0;
            segment_top_next     = '0;
            white_run_start_next = '0;
            in_white_next        = 1'b1;
            row_has_ink_next     = 1'b0;
        end
        else if (head_data.row_end)
        begin
            row_index_next   = row_index_reg + 1'b1;
            row_has_ink_next = 1'b0;
        end
    end

    // hold tracking state, advance on pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg       <= '0;
            segment_top_reg     <= '0;
            white_run_start_reg <= '0;
            in_white_reg        <= 1'b1;
            row_has_ink_reg     <= 1'b0;
        end
        else if (pop)
        begin
            row_index_reg       <= row_index_next;
            segment_top_reg     <= segment_top_next;
            white_run_start_reg <= white_run_start_next;
            in_white_reg        <= in_white_next;
            row_has_ink_reg     <= row_has_ink_next;
        end
    end

    // load results into the output register, second one into the hold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (pop && (split || head_data.image_end))
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= split && head_data.image_end;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_res_reg <= pend_res_reg;
            end
            else if (pop)
            begin
                out_res_reg  <= split ? split_res : close_res;
                pend_res_reg <= close_res;
            end
        end
    end

    assign seg.valid   = out_valid_reg;
    assign seg.seg_top = out_res_reg.seg_top;
    assign seg.seg_end = out_res_reg.seg_end;
    assign seg.closing = out_res_reg.closing;
    assign seg.last    = out_res_reg.last;

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("held result without a result in the output register");
    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && split && head_data.image_end) |=> (pend_valid_reg && out_valid_reg))
        else $error("second result of a pixel not held");
    a_pend_is_closing: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (pend_res_reg.closing && pend_res_reg.last
                            && !out_res_reg.last && !out_res_reg.closing))
        else $error("held result is not the closing result after a split");

endmodule

// File: rtl/core/whitespace_row_gap_segmenter.sv
// Whitespace row-gap segmenter top level: configuration registers and the
// front end, queue and back end. Depends on wsg_pkg, wsg_if and the wsg_ modules.
//
// Usage: pixels arrive on pix in raster order, one item per pixel, with
// row_end on the last pixel of each row and image_end on the last pixel of
// the image. Segments leave on seg as [seg_top, seg_end) row pairs; closing
// marks the final segment of an image, last the final result of a pixel.
// An item is taken at a rising edge with valid and ready both high.
// Throughput: one pixel per clock while the output register is free and no
// second result is held; a pixel that both splits and ends the image makes
// two results and holds the back end while the second waits behind the
// single-result output register. A result passes through the queue (written
// at the accepting edge) and then the back-end output register.
// The front end keeps taking pixels while the receiver stalls until the
// four-entry classification queue fills; then pix.ready drops.
// Reset: white_threshold returns to 62500, min_gap to 50, the queue empties
// and the row tracking returns to row 0 inside a white run. Configuration:
// cfg_we writes cfg_data into register cfg_index (0 white_threshold, 1 min_gap);
// the user must write only while the block is idle; it is not enforced.
module whitespace_row_gap_segmenter #(
    parameter int ROW_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rst_n,
    wsg_pix_if.sink                            pix,
    wsg_seg_if.source                          seg,
    input  logic                               cfg_we,
    input  logic [wsg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wsg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wsg_pkg::*;

    logic [THRESH_W-1:0] white_threshold_reg;
    logic [GAP_W-1:0]    min_gap_reg;

    logic       queue_full;
    logic       push;
    pix_class_t push_data;
    logic       pop;
    logic       head_valid;
    pix_class_t head_data;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_threshold_reg <= THRESH_RESET;
            min_gap_reg         <= GAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WHITE_THRESHOLD: white_threshold_reg <= THRESH_W'(cfg_data);
                CFG_MIN_GAP:         min_gap_reg         <= GAP_W'(cfg_data);
                default:             ;
            endcase
        end
    end

    wsg_front u_front (
        .pix             (pix),
        .white_threshold (white_threshold_reg),
        .queue_full      (queue_full),
        .push            (push),
        .push_data       (push_data)
    );

    wsg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    wsg_back #(
        .ROW_BITS (ROW_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .min_gap    (min_gap_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .seg        (seg)
    );

endmodule

// File: tb/tb_whitespace_row_gap_segmenter.sv
// Self-checking testbench for the whitespace row-gap segmenter: a directed
// table and random images, checked against hand-typed results and a behavioral row tracker.
// Depends on wsg_pkg, wsg_if and the whitespace_row_gap_segmenter RTL.
module tb_whitespace_row_gap_segmenter;
    timeunit 1ns;
    timeprecision 1ps;
    import wsg_pkg::*;

    localparam int RANDOM_PIXELS = 950;
    localparam int PHASE_PIXELS  = 120;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam logic [THRESH_W-1:0] THRESH_MAX = 18'd195075;
    localparam logic [GAP_W-1:0]    GAP_MAX    = 12'd4095;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              row_end;
        logic              image_end;
    } pixel_t;

    typedef enum logic [1:0] {
        DIR_PIXEL,
        DIR_THRESH,
        DIR_GAP
    } dir_kind_e;

    typedef struct packed {
        dir_kind_e             kind;
        logic [CFG_DATA_W-1:0] value;
        pixel_t                px;
        logic                  typed;
        seg_res_t              seg;
    } dir_row_t;

    // Directed stimulus: pixel rows, register writes and hand-typed results
    localparam int DIR_ROWS = 26;
    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        // reset settings: single-pixel images, ink then white
        '{DIR_PIXEL, 18'd0, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1}, 1'b1, '{12'd0, 12'd0, 1'b1, 1'b1}},
        '{DIR_PIXEL, 18'd0, '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1}, 1'b1,
          '{12'd0, 12'd0, 1'b1, 1'b1}},
        // gap of one row, ink exactly at the threshold, image end without row end
        '{DIR_GAP, 18'd1, '0, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0}, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd250, 8'd0, 8'd0, 1'b0, 1'b0}, 1'b1, '{12'd0, 12'd0, 1'b0, 1'b1}},
        '{DIR_PIXEL, 18'd0, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd250, 8'd1, 8'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd0, 8'd255, 8'd0, 1'b0, 1'b1}, 1'b1, '{12'd1, 12'd2, 1'b1, 1'b1}},
        // highest threshold: every pixel is ink
        '{DIR_THRESH, 18'd195075, '0, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1}, 1'b1,
          '{12'd0, 12'd0, 1'b1, 1'b1}},
        // zero threshold: split and closing on the same pixel
        '{DIR_THRESH, 18'd0, '0, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd0, 8'd0, 8'd1, 1'b1, 1'b0}, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1}, 1'b0, '0},
        // zero gap: every ink row after a white row splits, zero-height first segment
        '{DIR_GAP, 18'd0, '0, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b1, '{12'd0, 12'd0, 1'b0, 1'b1}},
        '{DIR_PIXEL, 18'd0, '{8'd1, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b1, '{12'd0, 12'd1, 1'b0, 1'b1}},
        '{DIR_PIXEL, 18'd0, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b1}, 1'b1, '{12'd2, 12'd4, 1'b1, 1'b1}},
        // back to the reset threshold, gap of two rows with a wide second white row
        '{DIR_THRESH, 18'd62500, '0, 1'b0, '0},
        '{DIR_GAP, 18'd2, '0, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd255, 8'd0, 8'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd200, 8'd200, 8'd0, 1'b0, 1'b0}, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0}, 1'b0, '0},
        '{DIR_PIXEL, 18'd0, '{8'd10, 8'd20, 8'd30, 1'b0, 1'b0}, 1'b1, '{12'd0, 12'd0, 1'b0, 1'b1}},
        '{DIR_PIXEL, 18'd0, '{8'd255, 8'd255, 8'd255, 1'b0, 1'b1}, 1'b1,
          '{12'd2, 12'd2, 1'b1, 1'b1}}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wsg_pix_if pix_ch ();
    wsg_seg_if seg_ch ();

    whitespace_row_gap_segmenter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_ch),
        .seg       (seg_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Row tracker state and its copy of the registers
    logic [THRESH_W-1:0] cfg_thresh;
    logic [GAP_W-1:0]    cfg_gap;
    logic [SEG_W-1:0]    row_now;
    logic [SEG_W-1:0]    top_now;
    logic [SEG_W-1:0]    white_from;
    logic                in_gap;
    logic                row_inked;
    seg_res_t            made_segs [0:1];

    seg_res_t pending_segs [$];
    int       mismatches;
    int       quiet_cycles;
    int       burst_left;
    int       pixels_sent;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void clear_rows();
        row_now    = '0;
        top_now    = '0;
        white_from = '0;
        in_gap     = 1'b1;
        row_inked  = 1'b0;
    endfunction

    // Advance the row tracker by one pixel; returns the number of segments made
    function automatic int track_rows(input pixel_t p);
        int unsigned      energy;
        logic [SEG_W-1:0] span;
        int               n;
        energy = 32'(p.red) * 32'(p.red) + 32'(p.green) * 32'(p.green)
               + 32'(p.blue) * 32'(p.blue);
        n = 0;
        // first ink of a row closes a long enough white run
        if (energy <= 32'(cfg_thresh) && !row_inked)
        begin
            row_inked = 1'b1;
            if (in_gap)
            begin
                span   = row_now - white_from;
                in_gap = 1'b0;
                if (span >= cfg_gap)
                begin
                    made_segs[n] = '{top_now, white_from, 1'b0, 1'b0};
                    n++;
                    top_now = row_now;
                end
            end
        end
        // row end, and image end which also ends the row
        if (p.row_end || p.image_end)
        begin
            if (!row_inked && !in_gap)
            begin
                in_gap     = 1'b1;
                white_from = row_now;
            end
            if (p.image_end)
            begin
                made_segs[n] = '{top_now, in_gap ? white_from : row_now, 1'b1, 1'b0};
                n++;
                clear_rows();
            end
            else
            begin
                row_now   = row_now + 1'b1;
                row_inked = 1'b0;
            end
        end
        if (n > 0)
            made_segs[n-1].last = 1'b1;
        return n;
    endfunction

    // Send one pixel item in bursts with random gaps, then predict its segments
    task automatic push_pixel(input pixel_t p, input logic typed, input seg_res_t typed_seg);
        int n;
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.red       <= p.red;
        pix_ch.green     <= p.green;
        pix_ch.blue      <= p.blue;
        pix_ch.row_end   <= p.row_end;
        pix_ch.image_end <= p.image_end;
        do @(posedge clk); while (!pix_ch.ready);
        burst_left--;
        pixels_sent++;
        n = track_rows(p);
        if (typed)
            pending_segs.push_back(typed_seg);
        else
            for (int k = 0; k < n; k++)
                pending_segs.push_back(made_segs[k]);
    endtask

    // Drop valid and hold until every segment is back and the pipe is empty
    task automatic drain_segments();
        pix_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_segs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WHITE_THRESHOLD: cfg_thresh = val[THRESH_W-1:0];
            CFG_MIN_GAP:         cfg_gap    = val[GAP_W-1:0];
            default:             ;
        endcase
        @(posedge clk);
    endtask

    // Random image: white rows, ink rows with white pixels, noise rows
    task automatic send_image();
        int     rows;
        int     width;
        int     style;
        logic   stop;
        pixel_t p;
        rows = $urandom_range(1, 14);
        stop = 1'b0;
        for (int r = 0; r < rows && !stop; r++)
        begin
            style = $urandom_range(0, 9);
            width = $urandom_range(1, 5);
            for (int c = 0; c < width && !stop; c++)
            begin
                if (style < 5 || (style < 9 && $urandom_range(0, 1) == 0))
                begin
                    p.red   = CHAN_W'($urandom_range(180, 255));
                    p.green = CHAN_W'($urandom_range(180, 255));
                    p.blue  = CHAN_W'($urandom_range(180, 255));
                end
                else if (style < 9)
                begin
                    p.red   = CHAN_W'($urandom_range(0, 140));
                    p.green = CHAN_W'($urandom_range(0, 140));
                    p.blue  = CHAN_W'($urandom_range(0, 140));
                end
                else
                begin
                    p.red   = CHAN_W'($urandom_range(0, 255));
                    p.green = CHAN_W'($urandom_range(0, 255));
                    p.blue  = CHAN_W'($urandom_range(0, 255));
                end
                p.row_end   = (c == width - 1);
                p.image_end = 1'b0;
                if (r == rows - 1 && c == width - 1)
                begin
                    p.image_end = 1'b1;
                    p.row_end   = 1'($urandom_range(0, 1));
                end
                else if ($urandom_range(0, 59) == 0)
                begin
                    // cut the image short, possibly mid-row
                    p.image_end = 1'b1;
                    p.row_end   = 1'($urandom_range(0, 1));
                    stop        = 1'b1;
                end
                push_pixel(p, 1'b0, '0);
            end
        end
    endtask

    // Receiver: alternate between always ready, random, periodic and long stalls
    initial
    begin
        int mode;
        int span;
        seg_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            for (int k = 0; k < span; k++)
            begin
                @(posedge clk);
                case (mode)
                    0:       seg_ch.ready <= 1'b1;
                    1:       seg_ch.ready <= 1'($urandom_range(0, 1));
                    2:       seg_ch.ready <= (k % 7) >= 3;
                    default: seg_ch.ready <= (k % 40) >= 25;
                endcase
            end
        end
    end

    // Compare each returned segment with the oldest prediction
    always @(posedge clk)
    begin
        seg_res_t want;
        if (rst_n && seg_ch.valid && seg_ch.ready)
        begin
            if (pending_segs.size() == 0)
            begin
                $display("%0t: unexpected segment top=%0d end=%0d closing=%0b last=%0b",
                         $time, seg_ch.seg_top, seg_ch.seg_end, seg_ch.closing, seg_ch.last);
                mismatches++;
            end
            else
            begin
                want = pending_segs.pop_front();
                if (seg_ch.seg_top !== want.seg_top || seg_ch.seg_end !== want.seg_end
                    || seg_ch.closing !== want.closing || seg_ch.last !== want.last)
                begin
                    $display("%0t: segment mismatch exp top=%0d end=%0d closing=%0b last=%0b",
                             $time, want.seg_top, want.seg_end, want.closing, want.last);
                    $display("%0t:                  got top=%0d end=%0d closing=%0b last=%0b",
                             $time, seg_ch.seg_top, seg_ch.seg_end, seg_ch.closing,
                             seg_ch.last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((pix_ch.valid && pix_ch.ready) || (seg_ch.valid && seg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        logic [THRESH_W-1:0]   thr;
        logic [GAP_W-1:0]      gap;
        int                    phase_start;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_WHITE_THRESHOLD;
        cfg_data         <= '0;
        pix_ch.valid     <= 1'b0;
        pix_ch.red       <= '0;
        pix_ch.green     <= '0;
        pix_ch.blue      <= '0;
        pix_ch.row_end   <= 1'b0;
        pix_ch.image_end <= 1'b0;
        mismatches   = 0;
        quiet_cycles = 0;
        burst_left   = 0;
        pixels_sent  = 0;
        cfg_thresh   = THRESH_RESET;
        cfg_gap      = GAP_RESET;
        clear_rows();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            case (DIRECTED[i].kind)
                DIR_THRESH:
                begin
                    drain_segments();
                    write_reg(CFG_WHITE_THRESHOLD, DIRECTED[i].value);
                end
                DIR_GAP:
                begin
                    drain_segments();
                    write_reg(CFG_MIN_GAP, DIRECTED[i].value);
                end
                default:
                    push_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].seg);
            endcase
        end

        // random phases, each under its own register settings
        phase_start = pixels_sent;
        while (pixels_sent - phase_start < RANDOM_PIXELS)
        begin
            drain_segments();
            case ($urandom_range(0, 5))
                0:       thr = '0;
                1:       thr = THRESH_MAX;
                2, 3:    thr = THRESH_RESET;
                default: thr = THRESH_W'($urandom_range(0, 195075));
            endcase
            case ($urandom_range(0, 9))
                0:       gap = '0;
                1:       gap = GAP_MAX;
                2, 3:    gap = 12'd1;
                4, 5:    gap = 12'd2;
                default: gap = GAP_W'($urandom_range(1, 5));
            endcase
            write_reg(CFG_WHITE_THRESHOLD, thr);
            write_reg(CFG_MIN_GAP, {6'($urandom_range(0, 63)), gap});
            begin
                int start;
                start = pixels_sent;
                while (pixels_sent - start < PHASE_PIXELS)
                    send_image();
            end
        end

        drain_segments();
        repeat (24) @(posedge clk);
        if (mismatches == 0 && pending_segs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/wsg_pkg.sv
rtl/core/wsg_if.sv
rtl/core/wsg_front.sv
rtl/core/wsg_queue.sv
rtl/core/wsg_back.sv
rtl/core/whitespace_row_gap_segmenter.sv
tb/tb_whitespace_row_gap_segmenter.sv
